>>> rtl/lcac_pkg.sv
`default_nettype none

package lcac_pkg;

  localparam int unsigned NODES_DEF = 1024;
  localparam int unsigned NODE_W    = 10;
  localparam int unsigned DEPTH_W   = 11;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 11'd2047;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic carry;
    logic zero;
  } alu_flags_t;

endpackage

`default_nettype wire

>>> rtl/lcac_alu.sv
`default_nettype none

module lcac_alu #(
  parameter int unsigned W = 17
) (
  input  var lcac_pkg::alu_op_e op_i,
  input  wire logic [W-1:0]     a_i,
  input  wire logic [W-1:0]     b_i,
  output logic [W-1:0]          res_o,
  output lcac_pkg::alu_flags_t  flags_o
);

  logic [W:0] sum;

  always_comb begin
    case (op_i)
      lcac_pkg::ALU_ADD: sum = {1'b0, a_i} + {1'b0, b_i};
      lcac_pkg::ALU_SUB: sum = {1'b0, a_i} - {1'b0, b_i};
      default:           sum = '0;
    endcase
  end

  assign res_o         = sum[W-1:0];
  assign flags_o.carry = sum[W];
  assign flags_o.zero  = (sum[W-1:0] == '0);

endmodule

`default_nettype wire

>>> rtl/lcac_tables.sv
`default_nettype none

module lcac_tables #(
  parameter int unsigned NODES = lcac_pkg::NODES_DEF,
  localparam int unsigned AW   = $clog2(NODES)
) (
  input  wire logic                         clk_i,
  input  wire logic [AW-1:0]                raddr0_i,
  input  wire logic [AW-1:0]                raddr1_i,
  output logic [AW-1:0]                     parent0_o,
  output logic [AW-1:0]                     parent1_o,
  output logic [lcac_pkg::DEPTH_W-1:0]      depth0_o,
  output logic [lcac_pkg::DEPTH_W-1:0]      depth1_o,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [AW-1:0]                wparent_i,
  input  wire logic [lcac_pkg::DEPTH_W-1:0] wdepth_i
);

  logic [AW-1:0]                parent_mem [NODES];
  logic [lcac_pkg::DEPTH_W-1:0] depth_mem  [NODES];

  logic [AW-1:0]                par0_q, par1_q;
  logic [lcac_pkg::DEPTH_W-1:0] dep0_q, dep1_q;
  logic                         zero0_q, zero1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      parent_mem[waddr_i] <= wparent_i;
      depth_mem[waddr_i]  <= wdepth_i;
    end
  end

  always_ff @(posedge clk_i) begin
    par0_q  <= parent_mem[raddr0_i];
    par1_q  <= parent_mem[raddr1_i];
    dep0_q  <= depth_mem[raddr0_i];
    dep1_q  <= depth_mem[raddr1_i];
    zero0_q <= (raddr0_i == '0);
    zero1_q <= (raddr1_i == '0);
  end

  // The sentinel node is never written and always reads as depth 0, parent 0.
  assign parent0_o = zero0_q ? '0 : par0_q;
  assign parent1_o = zero1_q ? '0 : par1_q;
  assign depth0_o  = zero0_q ? '0 : dep0_q;
  assign depth1_o  = zero1_q ? '0 : dep1_q;

endmodule

`default_nettype wire

>>> rtl/lcac_engine.sv
`default_nettype none

module lcac_engine #(
  parameter int unsigned NODES = lcac_pkg::NODES_DEF,
  localparam int unsigned AW   = $clog2(NODES),
  localparam int unsigned UW   = (AW > lcac_pkg::DEPTH_W) ? AW : lcac_pkg::DEPTH_W,
  localparam int unsigned W    = UW + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         kind_i,
  input  wire logic [lcac_pkg::NODE_W-1:0]  node_a_i,
  input  wire logic [lcac_pkg::NODE_W-1:0]  node_b_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [lcac_pkg::NODE_W-1:0]       ancestor_o,
  output logic [AW-1:0]                     raddr0_o,
  output logic [AW-1:0]                     raddr1_o,
  input  wire logic [AW-1:0]                parent0_i,
  input  wire logic [AW-1:0]                parent1_i,
  input  wire logic [lcac_pkg::DEPTH_W-1:0] depth0_i,
  input  wire logic [lcac_pkg::DEPTH_W-1:0] depth1_i,
  output logic                              we_o,
  output logic [AW-1:0]                     waddr_o,
  output logic [AW-1:0]                     wparent_o,
  output logic [lcac_pkg::DEPTH_W-1:0]      wdepth_o,
  output lcac_pkg::alu_op_e                 alu_op_o,
  output logic [W-1:0]                      alu_a_o,
  output logic [W-1:0]                      alu_b_o,
  input  wire logic [W-1:0]                 alu_res_i,
  input  var lcac_pkg::alu_flags_t          alu_flags_i
);

  localparam int unsigned SW = $clog2(NODES + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LDWR  = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_LIFT  = 5'b01000,
    ST_CLIMB = 5'b10000
  } state_e;

  function automatic logic [AW-1:0] to_idx(logic [lcac_pkg::NODE_W-1:0] id);
    if (32'(id) < 32'(NODES)) begin
      return AW'(id);
    end
    return '0;
  endfunction

  state_e                       state_q, state_d;
  logic [AW-1:0]                a_q, a_d, b_q, b_d;
  logic [lcac_pkg::DEPTH_W-1:0] diff_q, diff_d;
  logic [SW-1:0]                steps_q, steps_d;
  logic                         valid_q, valid_d;
  logic [AW-1:0]                anc_q, anc_d;
  logic                         accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    a_d      = a_q;
    b_d      = b_q;
    diff_d   = diff_q;
    steps_d  = steps_q;
    valid_d  = 1'b0;
    anc_d    = anc_q;
    we_o     = 1'b0;
    wdepth_o = '0;
    alu_op_o = lcac_pkg::ALU_SUB;
    alu_a_o  = '0;
    alu_b_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          a_d     = to_idx(node_a_i);
          b_d     = to_idx(node_b_i);
          state_d = kind_i ? ST_CMP : ST_LDWR;
        end
      end
      ST_LDWR: begin
        alu_op_o = lcac_pkg::ALU_ADD;
        alu_a_o  = W'(depth1_i);
        alu_b_o  = W'(1);
        wdepth_o = alu_res_i[lcac_pkg::DEPTH_W] ? lcac_pkg::DEPTH_MAX
                                                : alu_res_i[lcac_pkg::DEPTH_W-1:0];
        we_o     = (a_q != '0);
        state_d  = ST_IDLE;
      end
      ST_CMP: begin
        alu_a_o = W'(depth0_i);
        alu_b_o = W'(depth1_i);
        if (alu_flags_i.carry) begin
          a_d = b_q;
          b_d = a_q;
        end else begin
          diff_d  = alu_res_i[lcac_pkg::DEPTH_W-1:0];
          state_d = ST_LIFT;
        end
      end
      ST_LIFT: begin
        alu_a_o = W'(diff_q);
        alu_b_o = W'(1);
        if (diff_q != '0) begin
          a_d    = parent0_i;
          diff_d = alu_res_i[lcac_pkg::DEPTH_W-1:0];
        end else if (a_q == b_q) begin
          valid_d = 1'b1;
          anc_d   = a_q;
          state_d = ST_IDLE;
        end else begin
          steps_d = '0;
          state_d = ST_CLIMB;
        end
      end
      ST_CLIMB: begin
        alu_a_o = W'(parent0_i);
        alu_b_o = W'(parent1_i);
        if (alu_flags_i.zero || (steps_q == SW'(NODES))) begin
          valid_d = 1'b1;
          anc_d   = parent0_i;
          state_d = ST_IDLE;
        end else begin
          a_d     = parent0_i;
          b_d     = parent1_i;
          steps_d = steps_q + SW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    diff_q  <= diff_d;
    steps_q <= steps_d;
    anc_q   <= anc_d;
  end

  // Reads follow the next pointers, so the table outputs always belong to a_q and b_q.
  assign raddr0_o   = a_d;
  assign raddr1_o   = b_d;
  assign waddr_o    = a_q;
  assign wparent_o  = b_q;
  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = valid_q;
  assign ancestor_o = lcac_pkg::NODE_W'(anc_q);

`ifndef ASSERT_OFF
  ap_write_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> state_q == ST_LDWR)
    else $error("table write outside a load");
  ap_done_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == ST_LIFT || state_q == ST_CLIMB))
    else $error("result without a query");
  ap_load_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !kind_i) |=> state_q == ST_LDWR)
    else $error("load request did not reach the write step");
  ap_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLIMB |-> steps_q <= SW'(NODES))
    else $error("climb step count out of bound");
`endif

endmodule

`default_nettype wire

>>> rtl/lowest_common_ancestor_climb_core.sv
`default_nettype none

// Load request: busy during the write step; a new request is taken only while busy is low.
// Query request: compare depths (swap if the second node is deeper), lift the deeper node
// by the difference, then, if they differ, climb until parents match or NODES steps pass.
// Each step is one read of the dual-port tables and one pass of the shared ALU.
// Reset clears only the sequencer; tables are undefined until loaded, node 0 reads as 0.
// done_o is a one-cycle strobe; the receiver cannot stall it.
module lowest_common_ancestor_climb_core #(
  parameter int unsigned NODES = lcac_pkg::NODES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  input  wire logic                        kind_i,
  input  wire logic [lcac_pkg::NODE_W-1:0] node_a_i,
  input  wire logic [lcac_pkg::NODE_W-1:0] node_b_i,
  output logic                             busy,
  output logic                             done_o,
  output logic [lcac_pkg::NODE_W-1:0]      ancestor_o
);

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned UW = (AW > lcac_pkg::DEPTH_W) ? AW : lcac_pkg::DEPTH_W;
  localparam int unsigned W  = UW + 1;

  logic [AW-1:0]                raddr0, raddr1, parent0, parent1;
  logic [lcac_pkg::DEPTH_W-1:0] depth0, depth1, wdepth;
  logic                         we;
  logic [AW-1:0]                waddr, wparent;
  lcac_pkg::alu_op_e            alu_op;
  logic [W-1:0]                 alu_a, alu_b, alu_res;
  lcac_pkg::alu_flags_t         alu_flags;

  lcac_engine #(
    .NODES(NODES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .kind_i     (kind_i),
    .node_a_i   (node_a_i),
    .node_b_i   (node_b_i),
    .busy_o     (busy),
    .done_o     (done_o),
    .ancestor_o (ancestor_o),
    .raddr0_o   (raddr0),
    .raddr1_o   (raddr1),
    .parent0_i  (parent0),
    .parent1_i  (parent1),
    .depth0_i   (depth0),
    .depth1_i   (depth1),
    .we_o       (we),
    .waddr_o    (waddr),
    .wparent_o  (wparent),
    .wdepth_o   (wdepth),
    .alu_op_o   (alu_op),
    .alu_a_o    (alu_a),
    .alu_b_o    (alu_b),
    .alu_res_i  (alu_res),
    .alu_flags_i(alu_flags)
  );

  lcac_tables #(
    .NODES(NODES)
  ) u_tables (
    .clk_i    (clk_i),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .parent0_o(parent0),
    .parent1_o(parent1),
    .depth0_o (depth0),
    .depth1_o (depth1),
    .we_i     (we),
    .waddr_i  (waddr),
    .wparent_i(wparent),
    .wdepth_i (wdepth)
  );

  lcac_alu #(
    .W(W)
  ) u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .flags_o(alu_flags)
  );

endmodule

`default_nettype wire

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODE_CNT    = lcac_pkg::NODES_DEF;
  localparam int unsigned RANDOM_REQS = 1100;
  localparam int unsigned CYCLE_LIMIT = 40_000_000;

  typedef logic [lcac_pkg::NODE_W-1:0]  node_t;
  typedef logic [lcac_pkg::DEPTH_W-1:0] depth_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_e;

  logic  clk_i;
  logic  rst_ni   = 1'b0;
  logic  start    = 1'b0;
  logic  kind_i   = REQ_LOAD;
  node_t node_a_i = '0;
  node_t node_b_i = '0;
  logic  busy;
  logic  done_o;
  node_t ancestor_o;

  node_t       parent_mem [NODE_CNT];
  depth_t      depth_mem  [NODE_CNT];
  bit          is_loaded  [NODE_CNT];
  node_t       loaded_q [$];
  node_t       lca_expect_q [$];
  int unsigned err_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned pending_gap = 0;
  bit          burst_mode  = 1'b0;

  lowest_common_ancestor_climb_core #(
    .NODES(NODE_CNT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .kind_i    (kind_i),
    .node_a_i  (node_a_i),
    .node_b_i  (node_b_i),
    .busy      (busy),
    .done_o    (done_o),
    .ancestor_o(ancestor_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic node_t climb_lca(node_t a, node_t b);
    node_t       x;
    node_t       y;
    node_t       t;
    int unsigned diff;
    int unsigned steps;
    x = a;
    y = b;
    if (depth_mem[x] < depth_mem[y]) begin
      t = x;
      x = y;
      y = t;
    end
    diff = depth_mem[x] - depth_mem[y];
    while (diff > 0) begin
      x = parent_mem[x];
      diff--;
    end
    if (x == y) return x;
    steps = 0;
    while (steps < NODE_CNT && parent_mem[x] != parent_mem[y]) begin
      x = parent_mem[x];
      y = parent_mem[y];
      steps++;
    end
    return parent_mem[x];
  endfunction

  function automatic void store_node(node_t a, node_t b);
    int unsigned d;
    if (a == '0) return;
    d = depth_mem[b] + 1;
    if (d > lcac_pkg::DEPTH_MAX) d = lcac_pkg::DEPTH_MAX;
    parent_mem[a] = b;
    depth_mem[a]  = depth_t'(d);
  endfunction

  // Parents are drawn only from nodes first loaded earlier, which keeps the tree acyclic.
  function automatic node_t pick_parent(int unsigned limit);
    if (limit == 0 || $urandom_range(0, 7) == 0) return '0;
    return loaded_q[$urandom_range(0, limit - 1)];
  endfunction

  function automatic node_t pick_any_node();
    if ($urandom_range(0, 15) == 0) return '0;
    return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
  endfunction

  task automatic send_req(input req_kind_e kind, input node_t a, input node_t b);
    repeat (pending_gap) @(posedge clk_i);
    start    <= 1'b1;
    kind_i   <= kind;
    node_a_i <= a;
    node_b_i <= b;
    do @(posedge clk_i); while (busy);
    if (kind == REQ_QUERY) lca_expect_q = {lca_expect_q, climb_lca(a, b)};
    else store_node(a, b);
    pending_gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (pending_gap != 0) start <= 1'b0;
  endtask

  task automatic load_req(input node_t a, input node_t b);
    send_req(REQ_LOAD, a, b);
    if (a != '0 && !is_loaded[a]) begin
      is_loaded[a] = 1'b1;
      loaded_q = {loaded_q, a};
    end
  endtask

  task automatic wait_results_drained();
    if (pending_gap == 0) start <= 1'b0;
    @(posedge clk_i);
    while (lca_expect_q.size() != 0) @(posedge clk_i);
    pending_gap = 0;
  endtask

  task automatic test_directed_tree();
    load_req(10'd1, 10'd0);
    load_req(10'd1023, 10'd1);
    load_req(10'd512, 10'd1);
    load_req(10'd2, 10'd512);
    load_req(10'd1022, 10'd0);
    load_req(10'd0, 10'd1023);
    send_req(REQ_QUERY, 10'd1023, 10'd512);
    send_req(REQ_QUERY, 10'd2, 10'd1023);
    send_req(REQ_QUERY, 10'd1023, 10'd2);
    send_req(REQ_QUERY, 10'd2, 10'd2);
    send_req(REQ_QUERY, 10'd2, 10'd1);
    send_req(REQ_QUERY, 10'd1, 10'd2);
    send_req(REQ_QUERY, 10'd0, 10'd2);
    send_req(REQ_QUERY, 10'd2, 10'd0);
    send_req(REQ_QUERY, 10'd1022, 10'd2);
    send_req(REQ_QUERY, 10'd0, 10'd0);
    wait_results_drained();
    load_req(10'd341, 10'd1022);
    load_req(10'd682, 10'd341);
    send_req(REQ_QUERY, 10'd682, 10'd1023);
    send_req(REQ_QUERY, 10'd682, 10'd1022);
    send_req(REQ_QUERY, 10'd1022, 10'd1022);
    wait_results_drained();
  endtask

  task automatic test_random_forest();
    int unsigned n;
    int unsigned roll;
    int unsigned idx;
    node_t       a;
    node_t       b;
    n = 0;
    while (n < RANDOM_REQS) begin
      if (n % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        load_req('0, pick_any_node());
      end else begin
        n++;
        if (roll < 50 && loaded_q.size() < NODE_CNT - 1) begin
          do a = node_t'($urandom_range(1, NODE_CNT - 1)); while (is_loaded[a]);
          b = ($urandom_range(0, 2) == 0) ? loaded_q[$] : pick_parent(loaded_q.size());
          load_req(a, b);
        end else if (roll < 60) begin
          idx = $urandom_range(0, loaded_q.size() - 1);
          load_req(loaded_q[idx], pick_parent(idx));
        end else begin
          send_req(REQ_QUERY, pick_any_node(), pick_any_node());
        end
      end
    end
    burst_mode = 1'b0;
    wait_results_drained();
  endtask

  // Two nodes are made each other's parent and reloaded until their depths saturate, then queried.
  task automatic test_depth_saturation();
    node_t x;
    node_t y;
    x = loaded_q[0];
    y = loaded_q[1];
    while (depth_mem[x] != lcac_pkg::DEPTH_MAX || depth_mem[y] != lcac_pkg::DEPTH_MAX) begin
      load_req(x, y);
      load_req(y, x);
    end
    load_req(x, y);
    load_req(y, x);
    send_req(REQ_QUERY, x, y);
    send_req(REQ_QUERY, y, x);
    send_req(REQ_QUERY, x, '0);
    repeat (4) send_req(REQ_QUERY, pick_any_node(), x);
  endtask

  always @(posedge clk_i) begin
    node_t want;
    if (rst_ni && done_o) begin
      if (lca_expect_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result: ancestor %0d", ancestor_o);
      end else begin
        want = lca_expect_q.pop_front();
        if (ancestor_o !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ancestor mismatch: expected %0d, got %0d", want, ancestor_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NODE_CNT; i++) begin
      parent_mem[i] = '0;
      depth_mem[i]  = '0;
      is_loaded[i]  = 1'b0;
    end
    is_loaded[0] = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_tree();
    test_random_forest();
    test_depth_saturation();
    wait_results_drained();
    repeat (32) @(posedge clk_i);
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> lowest_common_ancestor_climb_core.f
rtl/lcac_pkg.sv
rtl/lcac_alu.sv
rtl/lcac_tables.sv
rtl/lcac_engine.sv
rtl/lowest_common_ancestor_climb_core.sv
sim/tb.sv
